// ===== hw/rtl/swac_pkg.sv =====
package swac_pkg;

    localparam int RING_DEPTH  = 64;
    localparam int SAMPLE_W    = 48;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int SUM_W       = SAMPLE_W + ADDR_W;
    localparam int STEP_W      = $clog2(SUM_W + 1);
    localparam int CFG_W       = 7;
    localparam int CODE_W      = 2;
    localparam int IN_TDATA_W  = ((SAMPLE_W + CODE_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CODE_W + SAMPLE_W + CNT_W + CODE_W + 7) / 8) * 8;
    localparam int WINDOW_RESET = (RING_DEPTH < 60) ? RING_DEPTH : 60;

    typedef enum logic [CODE_W-1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_FAIL   = 2'd2,
        ACT_READD  = 2'd3
    } action_t;

    typedef enum logic [CODE_W-1:0] {
        OUTC_VALID    = 2'd0,
        OUTC_SECOND   = 2'd1,
        OUTC_NEGATIVE = 2'd2,
        OUTC_ERROR    = 2'd3
    } outcome_t;

    typedef enum logic [CODE_W-1:0] {
        CST_NOT_SUPPORTED = 2'd0,
        CST_INITIALIZED   = 2'd1,
        CST_WAIT_SECOND   = 2'd2,
        CST_ACTIVE        = 2'd3
    } counter_state_t;

    typedef enum logic [CODE_W-1:0] {
        RS_OK         = 2'd0,
        RS_NOT_ACTIVE = 2'd1,
        RS_SPAN       = 2'd2,
        RS_IGNORED    = 2'd3
    } result_status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_PUSH,
        FSM_WALK,
        FSM_DIV,
        FSM_FINISH
    } fsm_t;

    typedef struct packed {
        logic                start;
        logic [SUM_W-1:0]    dividend;
        logic [CNT_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/sliding_window_average_collector.sv =====
// Sliding-window moving average over a ring of the newest samples.
// Input transactions arrive on s_axis: tuser carries the action (sample,
// query, collection failed, counter re-added), tdata the sample value,
// its outcome code and the query span. Every input transaction yields
// exactly one result transaction on m_axis with a status, the average,
// the number of samples held and the counter state after the step.
// The window length is written on the cfg channel, which is ready while no
// transaction is in progress and then takes precedence over s_axis; a write
// empties the ring and deactivates the counter.
// A query whose span equals the window divides the running sum by the fill
// in the 54-step restoring divider; any other query walks min(fill, span)
// ring entries through the single memory read port, one per cycle, and
// then runs the same divider on their sum.
// One transaction is processed at a time; a new one is taken while the
// previous result still waits in the output register.
// Reset clears the ring state (empty, status not supported) and sets the
// window to 60. If the receiver stalls, the finished result holds in the
// output register and processing pauses before the next result.
module sliding_window_average_collector
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_value [47:0], sample_outcome [49:48], query_span [56:50]
    input  logic [swac_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // action [1:0]
    input  logic [swac_pkg::CODE_W-1:0]           s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // result_status [1:0], average [49:2], samples_held [56:50],
    // counter_state [58:57]
    output logic [swac_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swac_pkg::CFG_W-1:0]            cfg_data
);

    swac_pkg::fsm_t                    state_reg, state_next;
    swac_pkg::counter_state_t          status_reg, status_next;
    swac_pkg::result_status_t          rs_reg, rs_next;
    logic [swac_pkg::CNT_W-1:0]        fill_reg, fill_next;
    logic [swac_pkg::CNT_W-1:0]        window_reg, window_next;
    logic [swac_pkg::ADDR_W-1:0]       newest_reg, newest_next;
    logic [swac_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [swac_pkg::SUM_W-1:0]        acc_reg, acc_next;
    logic [swac_pkg::SAMPLE_W-1:0]     avg_reg, avg_next;
    logic [swac_pkg::SAMPLE_W-1:0]     val_reg, val_next;
    logic [swac_pkg::ADDR_W-1:0]       walk_addr_reg, walk_addr_next;
    logic [swac_pkg::CNT_W-1:0]        walk_left_reg, walk_left_next;
    logic [swac_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              pend_reg, pend_next;
    logic                              out_valid_reg, out_valid_next;
    logic [swac_pkg::OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    swac_pkg::action_t                 in_action;
    swac_pkg::outcome_t                in_outcome;
    logic [swac_pkg::SAMPLE_W-1:0]     in_value;
    logic [swac_pkg::CNT_W-1:0]        in_span;
    logic                              in_fire;
    logic                              cfg_fire;

    swac_pkg::fsm_t                    dec_route;
    swac_pkg::result_status_t          dec_rs;
    swac_pkg::counter_state_t          dec_status;
    logic                              dec_deact;
    logic [swac_pkg::CNT_W-1:0]        dec_cnt;

    logic [swac_pkg::ADDR_W-1:0]       push_pos;
    logic                              evict;
    logic                              walk_done;
    logic                              out_free;
    logic [swac_pkg::CNT_W-1:0]        cfg_window;

    logic                              mem_we;
    logic                              mem_re;
    logic [swac_pkg::ADDR_W-1:0]       mem_raddr;
    logic [swac_pkg::SAMPLE_W-1:0]     mem_rdata;
    swac_pkg::div_req_t                div_req;
    swac_pkg::div_rsp_t                div_rsp;

    assign in_action  = swac_pkg::action_t'(s_axis_tuser);
    assign in_value   = s_axis_tdata[swac_pkg::SAMPLE_W-1:0];
    assign in_outcome = swac_pkg::outcome_t'(
        s_axis_tdata[swac_pkg::SAMPLE_W +: swac_pkg::CODE_W]);
    assign in_span    = s_axis_tdata[swac_pkg::SAMPLE_W + swac_pkg::CODE_W +: swac_pkg::CNT_W];

    // A waiting window write is taken before any input transaction.
    assign s_axis_tready = (state_reg == swac_pkg::FSM_IDLE) && !cfg_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = (state_reg == swac_pkg::FSM_IDLE);
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign walk_done     = (walk_left_reg == '0) && !pend_reg;

    // The next slot follows the newest one and wraps at the window length.
    always_comb
    begin
        if (fill_reg == '0)
        begin
            push_pos = '0;
        end
        else if ((swac_pkg::CNT_W'(newest_reg) + 1'b1) == window_reg)
        begin
            push_pos = '0;
        end
        else
        begin
            push_pos = newest_reg + 1'b1;
        end
    end

    assign evict = (fill_reg >= window_reg);

    always_comb
    begin
        if (int'(cfg_data) < 1)
        begin
            cfg_window = swac_pkg::CNT_W'(1);
        end
        else if (int'(cfg_data) > swac_pkg::RING_DEPTH)
        begin
            cfg_window = swac_pkg::CNT_W'(swac_pkg::RING_DEPTH);
        end
        else
        begin
            cfg_window = swac_pkg::CNT_W'(cfg_data);
        end
    end

    // Decode of the transaction offered at the input.
    always_comb
    begin
        dec_route  = swac_pkg::FSM_FINISH;
        dec_rs     = swac_pkg::RS_OK;
        dec_status = status_reg;
        dec_deact  = 1'b0;
        dec_cnt    = (fill_reg < in_span) ? fill_reg : in_span;
        case (in_action)
            swac_pkg::ACT_SAMPLE:
            begin
                if (status_reg == swac_pkg::CST_NOT_SUPPORTED
                    || in_outcome == swac_pkg::OUTC_NEGATIVE)
                begin
                    dec_rs = swac_pkg::RS_IGNORED;
                end
                else if (in_outcome == swac_pkg::OUTC_VALID)
                begin
                    dec_status = swac_pkg::CST_ACTIVE;
                    dec_route  = swac_pkg::FSM_PUSH;
                end
                else if (in_outcome == swac_pkg::OUTC_SECOND)
                begin
                    dec_status = swac_pkg::CST_WAIT_SECOND;
                end
                else
                begin
                    dec_deact = 1'b1;
                    dec_rs    = swac_pkg::RS_NOT_ACTIVE;
                end
            end
            swac_pkg::ACT_QUERY:
            begin
                if (status_reg != swac_pkg::CST_ACTIVE)
                begin
                    dec_rs = swac_pkg::RS_NOT_ACTIVE;
                end
                else if (in_span == '0 || in_span > window_reg)
                begin
                    dec_rs = swac_pkg::RS_SPAN;
                end
                else if (fill_reg == '0)
                begin
                    dec_rs = swac_pkg::RS_NOT_ACTIVE;
                end
                else if (in_span == window_reg)
                begin
                    dec_cnt   = fill_reg;
                    dec_route = swac_pkg::FSM_DIV;
                end
                else
                begin
                    dec_route = swac_pkg::FSM_WALK;
                end
            end
            swac_pkg::ACT_FAIL:
            begin
                dec_deact = 1'b1;
            end
            swac_pkg::ACT_READD:
            begin
                if (status_reg == swac_pkg::CST_NOT_SUPPORTED)
                begin
                    dec_status = swac_pkg::CST_INITIALIZED;
                end
                else
                begin
                    dec_rs = swac_pkg::RS_IGNORED;
                end
            end
            default:
            begin
                dec_route = swac_pkg::FSM_FINISH;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swac_pkg::FSM_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = dec_route;
                end
            end
            swac_pkg::FSM_PUSH:
            begin
                state_next = swac_pkg::FSM_FINISH;
            end
            swac_pkg::FSM_WALK:
            begin
                if (walk_done)
                begin
                    state_next = swac_pkg::FSM_DIV;
                end
            end
            swac_pkg::FSM_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = swac_pkg::FSM_FINISH;
                end
            end
            swac_pkg::FSM_FINISH:
            begin
                if (out_free)
                begin
                    state_next = swac_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = swac_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        status_next    = status_reg;
        rs_next        = rs_reg;
        fill_next      = fill_reg;
        window_next    = window_reg;
        newest_next    = newest_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        avg_next       = avg_reg;
        val_next       = val_reg;
        walk_addr_next = walk_addr_reg;
        walk_left_next = walk_left_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = push_pos;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = cnt_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            swac_pkg::FSM_IDLE:
            begin
                if (in_fire)
                begin
                    rs_next        = dec_rs;
                    status_next    = dec_status;
                    avg_next       = '0;
                    val_next       = in_value;
                    cnt_next       = dec_cnt;
                    walk_addr_next = newest_reg;
                    walk_left_next = dec_cnt;
                    acc_next       = '0;
                    if (dec_deact)
                    begin
                        status_next = swac_pkg::CST_NOT_SUPPORTED;
                        fill_next   = '0;
                        newest_next = '0;
                        sum_next    = '0;
                    end
                    // Fetch the slot to be overwritten so that its value can
                    // leave the running sum next cycle.
                    if (dec_route == swac_pkg::FSM_PUSH)
                    begin
                        mem_re = 1'b1;
                    end
                    if (dec_route == swac_pkg::FSM_DIV)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = sum_reg;
                        div_req.divisor  = dec_cnt;
                    end
                end
                else if (cfg_fire)
                begin
                    window_next = cfg_window;
                    status_next = swac_pkg::CST_NOT_SUPPORTED;
                    fill_next   = '0;
                    newest_next = '0;
                    sum_next    = '0;
                end
            end
            swac_pkg::FSM_PUSH:
            begin
                mem_we      = 1'b1;
                newest_next = push_pos;
                sum_next    = sum_reg
                              + {{swac_pkg::ADDR_W{val_reg[swac_pkg::SAMPLE_W-1]}}, val_reg}
                              - (evict ? {{swac_pkg::ADDR_W{mem_rdata[swac_pkg::SAMPLE_W-1]}},
                                          mem_rdata}
                                       : '0);
                if (!evict)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            swac_pkg::FSM_WALK:
            begin
                // Reads are issued back to back; data arrives in the next cycle.
                if (walk_left_reg != '0)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = walk_addr_reg;
                    pend_next      = 1'b1;
                    walk_left_next = walk_left_reg - 1'b1;
                    if (walk_addr_reg == '0)
                    begin
                        walk_addr_next = swac_pkg::ADDR_W'(window_reg - 1'b1);
                    end
                    else
                    begin
                        walk_addr_next = walk_addr_reg - 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    acc_next = acc_reg
                               + {{swac_pkg::ADDR_W{mem_rdata[swac_pkg::SAMPLE_W-1]}},
                                  mem_rdata};
                end
                if (walk_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = acc_reg;
                    div_req.divisor  = cnt_reg;
                end
            end
            swac_pkg::FSM_DIV:
            begin
                if (div_rsp.done)
                begin
                    avg_next = div_rsp.quotient;
                end
            end
            swac_pkg::FSM_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = swac_pkg::OUT_TDATA_W'({status_reg, fill_reg,
                                                             avg_reg, rs_reg});
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swac_pkg::FSM_IDLE;
            status_reg    <= swac_pkg::CST_NOT_SUPPORTED;
            fill_reg      <= '0;
            window_reg    <= swac_pkg::CNT_W'(swac_pkg::WINDOW_RESET);
            newest_reg    <= '0;
            sum_reg       <= '0;
            walk_left_reg <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            fill_reg      <= fill_next;
            window_reg    <= window_next;
            newest_reg    <= newest_next;
            sum_reg       <= sum_next;
            walk_left_reg <= walk_left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg        <= rs_next;
        acc_reg       <= acc_next;
        avg_reg       <= avg_next;
        val_reg       <= val_next;
        walk_addr_reg <= walk_addr_next;
        cnt_reg       <= cnt_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    swac_ring u_ring
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (push_pos),
        .wr_data (val_reg),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    swac_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

// ===== hw/rtl/swac_ring.sv =====
module swac_ring
(
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [swac_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [swac_pkg::SAMPLE_W-1:0]   wr_data,
    input  logic                            rd_en,
    input  logic [swac_pkg::ADDR_W-1:0]     rd_addr,
    output logic [swac_pkg::SAMPLE_W-1:0]   rd_data
);

    logic [swac_pkg::SAMPLE_W-1:0] mem [swac_pkg::RING_DEPTH];
    logic [swac_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/swac_div.sv =====
module swac_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  swac_pkg::div_req_t req,
    output swac_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           neg_reg, neg_next;
    logic [swac_pkg::STEP_W-1:0]    steps_reg, steps_next;
    logic [swac_pkg::SUM_W-1:0]     work_reg, work_next;
    logic [swac_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [swac_pkg::CNT_W-1:0]     dvs_reg, dvs_next;
    logic [swac_pkg::CNT_W:0]       shifted;
    logic [swac_pkg::CNT_W:0]       diff;
    logic [swac_pkg::SUM_W-1:0]     signed_q;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        steps_next = steps_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        shifted    = {rem_reg, work_reg[swac_pkg::SUM_W-1]};
        diff       = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            // Work on the magnitude and restore the sign at the end.
            neg_next   = req.dividend[swac_pkg::SUM_W-1];
            work_next  = req.dividend[swac_pkg::SUM_W-1] ? (~req.dividend + 1'b1)
                                                         : req.dividend;
            rem_next   = '0;
            dvs_next   = req.divisor;
            steps_next = swac_pkg::STEP_W'(swac_pkg::SUM_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next  = diff[swac_pkg::CNT_W-1:0];
                work_next = {work_reg[swac_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[swac_pkg::CNT_W-1:0];
                work_next = {work_reg[swac_pkg::SUM_W-2:0], 1'b0};
            end
            steps_next = steps_reg - 1'b1;
            if (steps_reg == swac_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign signed_q      = neg_reg ? (~work_reg + 1'b1) : work_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = signed_q[swac_pkg::SAMPLE_W-1:0];

endmodule
